// ===== sv/aqls_pkg.sv =====
// Shared types and constants for the adaptive quantizer-matrix level selector.
package aqls_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;
	localparam int QUEUE_DEPTH       = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ADAPTIVE_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD_ACTIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE_KB   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_MULTIPLIER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_NUMERATOR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_DENOMINATOR = 3'd7;

	localparam logic [7:0]  QP_VALID_LIMIT = 8'd52;
	localparam logic [7:0]  QP_RESET       = 8'd255;
	localparam logic [7:0]  QP_FLAT        = 8'd50;
	localparam logic [7:0]  QP_WEAK        = 8'd100;
	localparam logic [7:0]  QP_MEDIUM      = 8'd150;
	localparam logic [7:0]  QP_STRONG      = 8'd220;
	localparam logic [20:0] BITRATE_K      = 21'd2000000;
	localparam logic [5:0]  BR_STRONG      = 6'd25;

	localparam logic [4:0] LEVEL_NONE = 5'd16;
	localparam logic [4:0] LEVEL_6    = 5'd6;
	localparam logic [4:0] LEVEL_8    = 5'd8;
	localparam logic [4:0] LEVEL_10   = 5'd10;
	localparam logic [4:0] LEVEL_12   = 5'd12;
	localparam logic [4:0] LEVEL_14   = 5'd14;

	typedef struct packed {
		logic        adaptive_enable;
		logic        lookahead_active;
		logic [13:0] frame_width;
		logic [13:0] frame_height;
		logic [15:0] buffer_size_kb;
		logic [15:0] rate_multiplier;
		logic [31:0] rate_numerator;
		logic [31:0] rate_denominator;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_SHIFT,
		OP_FIXED,
		OP_SELECT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] qp;
	} cmd_t;

endpackage

// ===== sv/aqls_front.sv =====
// Front end: configuration registers and request classification.
module aqls_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [aqls_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aqls_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             req_type,
	input  logic [7:0]                       qp_value,
	input  logic                             matrix_preset,
	input  logic                             q_full,
	output logic                             q_push,
	output aqls_pkg::cmd_t                   q_cmd,
	output aqls_pkg::cfg_t                   cfg
);
	import aqls_pkg::*;

	cfg_t cfg_q;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                  <= '0;
			cfg_q.rate_numerator   <= 32'd30;
			cfg_q.rate_denominator <= 32'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ADAPTIVE_ENABLE:  cfg_q.adaptive_enable  <= cfg_wdata[0];
				REG_LOOKAHEAD_ACTIVE: cfg_q.lookahead_active <= cfg_wdata[0];
				REG_FRAME_WIDTH:      cfg_q.frame_width      <= cfg_wdata[13:0];
				REG_FRAME_HEIGHT:     cfg_q.frame_height     <= cfg_wdata[13:0];
				REG_BUFFER_SIZE_KB:   cfg_q.buffer_size_kb   <= cfg_wdata[15:0];
				REG_RATE_MULTIPLIER:  cfg_q.rate_multiplier  <= cfg_wdata[15:0];
				REG_RATE_NUMERATOR:   cfg_q.rate_numerator   <= cfg_wdata;
				REG_RATE_DENOMINATOR: cfg_q.rate_denominator <= cfg_wdata;
			endcase
		end
	end

	assign cfg      = cfg_q;
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// drop feedback while look-ahead owns the history
	always_comb begin
		q_cmd.qp = qp_value;
		if (!req_type) begin
			q_cmd.op = OP_SHIFT;
			q_push   = accept && !cfg_q.lookahead_active;
		end else begin
			q_push = accept;
			if (cfg_q.lookahead_active || matrix_preset || !cfg_q.adaptive_enable) begin
				q_cmd.op = OP_FIXED;
			end else begin
				q_cmd.op = OP_SELECT;
			end
		end
	end

endmodule

// ===== sv/aqls_queue.sv =====
// Short command queue between the front end and the back end.
module aqls_queue #(
	parameter int DEPTH = aqls_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  aqls_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           head_valid,
	output aqls_pkg::cmd_t head_cmd,
	input  logic           pop
);
	import aqls_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/aqls_back.sv =====
// Back end: QP history, averaging, bitrate arithmetic, level choice and result register.
module aqls_back #(
	parameter int HISTORY_DEPTH = aqls_pkg::HISTORY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  aqls_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  aqls_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           header_update,
	output logic           use_matrix,
	output logic [4:0]     matrix_level
);
	import aqls_pkg::*;

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = $clog2(51 * HISTORY_DEPTH + 1);
	localparam int CMP_W = SUM_W + 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SUM,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_ADD,
		S_DECIDE
	} state_t;

	state_t           state_q;
	logic [7:0]       hist_q [HISTORY_DEPTH];
	logic [IDX_W-1:0] idx_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      bm_q;
	logic [19:0]      mb_q;
	logic [52:0]      p_q;
	logic [51:0]      u_q;
	logic [63:0]      lo_q;
	logic [52:0]      hi_q;
	logic [56:0]      t25_q;
	logic [84:0]      lhs_q;

	logic             out_free;
	logic [7:0]       tail;
	logic [15:0]      mult_eff;
	logic [CMP_W-1:0] rnd;
	logic             avg_zero;
	logic [4:0]       level;

	assign out_free = !out_valid || !out_stall;
	assign tail     = hist_q[HISTORY_DEPTH-1];
	assign mult_eff = (cfg.rate_multiplier == '0) ? 16'd1 : cfg.rate_multiplier;
	assign q_pop    = (state_q == S_IDLE) && q_valid && (q_cmd.op != OP_FIXED || out_free);

	// rounded average vs count-scaled thresholds; a zero average compares bitrate instead
	always_comb begin
		rnd      = CMP_W'(sum_q) + CMP_W'(cnt_q >> 1);
		avg_zero = (cnt_q == '0) || (rnd < CMP_W'(cnt_q));
		if (avg_zero) begin
			if (lhs_q < 85'(t25_q)) begin
				level = LEVEL_8;
			end else if (lhs_q < 85'({t25_q, 1'b0})) begin
				level = LEVEL_10;
			end else begin
				level = LEVEL_12;
			end
		end else if (rnd < CMP_W'(QP_FLAT) * CMP_W'(cnt_q)) begin
			level = LEVEL_14;
		end else if (rnd < CMP_W'(QP_WEAK) * CMP_W'(cnt_q)) begin
			level = LEVEL_12;
		end else if (rnd < CMP_W'(QP_MEDIUM) * CMP_W'(cnt_q)) begin
			level = LEVEL_10;
		end else if (rnd < CMP_W'(QP_STRONG) * CMP_W'(cnt_q)) begin
			level = LEVEL_8;
		end else begin
			level = LEVEL_6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= QP_RESET;
			end
			idx_q         <= '0;
			sum_q         <= '0;
			cnt_q         <= '0;
			bm_q          <= '0;
			mb_q          <= '0;
			p_q           <= '0;
			u_q           <= '0;
			lo_q          <= '0;
			hi_q          <= '0;
			t25_q         <= '0;
			lhs_q         <= '0;
			out_valid     <= 1'b0;
			header_update <= 1'b0;
			use_matrix    <= 1'b0;
			matrix_level  <= LEVEL_NONE;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.op)
							OP_SHIFT: begin
								hist_q[0] <= q_cmd.qp;
								for (int i = 1; i < HISTORY_DEPTH; i++) begin
									hist_q[i] <= hist_q[i-1];
								end
							end
							OP_FIXED: begin
								out_valid     <= 1'b1;
								header_update <= 1'b0;
								use_matrix    <= 1'b0;
								matrix_level  <= LEVEL_NONE;
							end
							OP_SELECT: begin
								idx_q   <= '0;
								sum_q   <= '0;
								cnt_q   <= '0;
								state_q <= S_SUM;
							end
							default: ;
						endcase
					end
				end
				S_SUM: begin
					// rotate once through the history, reading the tail each cycle
					hist_q[0] <= tail;
					for (int i = 1; i < HISTORY_DEPTH; i++) begin
						hist_q[i] <= hist_q[i-1];
					end
					if (tail < QP_VALID_LIMIT) begin
						sum_q <= sum_q + SUM_W'(tail);
						cnt_q <= cnt_q + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_W'(HISTORY_DEPTH - 1)) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					bm_q    <= 32'(cfg.buffer_size_kb) * 32'(mult_eff);
					mb_q    <= 20'(cfg.frame_width[13:4]) * 20'(cfg.frame_height[13:4]);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					p_q     <= 53'(bm_q) * 53'(BITRATE_K);
					u_q     <= 52'(cfg.rate_numerator) * 52'(mb_q);
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					lo_q    <= 64'(p_q[31:0]) * 64'(cfg.rate_denominator);
					t25_q   <= 57'(u_q) * 57'(BR_STRONG);
					state_q <= S_MUL4;
				end
				S_MUL4: begin
					hi_q    <= 53'(p_q[52:32]) * 53'(cfg.rate_denominator);
					state_q <= S_ADD;
				end
				S_ADD: begin
					lhs_q   <= {hi_q, 32'b0} + 85'(lo_q);
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (out_free) begin
						out_valid     <= 1'b1;
						header_update <= 1'b1;
						use_matrix    <= 1'b1;
						matrix_level  <= level;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/adaptive_qmatrix_level_select.sv =====
// Top level of the adaptive quantizer-matrix level selector.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  in       | in_valid / in_stall       | req_type, qp_value, matrix_preset
//  out      | out_valid / out_stall     | header_update, use_matrix, matrix_level
//  cfg      | cfg_wr_en                 | cfg_index, cfg_wdata
//
// Feedback and fixed-answer requests are each handled in the back end's idle state.
// A selecting query first reads every entry on a pass through the rotating history,
// then takes five multiply/add steps and one decision step.
// Reset loads register defaults, fills the history with 255 and empties the queue.
// out_stall holds the result register; the back end waits, the two-entry queue fills,
// and then in_stall rises.
module adaptive_qmatrix_level_select #(
	parameter int HISTORY_DEPTH = aqls_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [aqls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aqls_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            req_type,
	input  logic [7:0]                      qp_value,
	input  logic                            matrix_preset,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            header_update,
	output logic                            use_matrix,
	output logic [4:0]                      matrix_level
);
	import aqls_pkg::*;

	cfg_t cfg;
	cmd_t push_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_full;
	logic q_valid;
	logic q_pop;

	aqls_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.qp_value      (qp_value),
		.matrix_preset (matrix_preset),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (push_cmd),
		.cfg           (cfg)
	);

	aqls_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (q_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop)
	);

	aqls_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_cmd         (head_cmd),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.header_update (header_update),
		.use_matrix    (use_matrix),
		.matrix_level  (matrix_level)
	);

endmodule

// ===== sv/aqls_checker.sv =====
// Port-level assertions for the level selector, bound to the top level.
module aqls_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       header_update,
	input logic       use_matrix,
	input logic [4:0] matrix_level
);
	import aqls_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(header_update) &&
			$stable(use_matrix) && $stable(matrix_level))
		else $error("result changed while stalled");

	a_flags_agree: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> header_update == use_matrix)
		else $error("header_update and use_matrix disagree");

	a_none_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !header_update |-> matrix_level == LEVEL_NONE)
		else $error("no-update result without level 16");

	a_level_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_update |-> matrix_level == LEVEL_6 ||
			matrix_level == LEVEL_8 || matrix_level == LEVEL_10 ||
			matrix_level == LEVEL_12 || matrix_level == LEVEL_14)
		else $error("selected level outside the level set");

endmodule

bind adaptive_qmatrix_level_select aqls_checker u_aqls_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.header_update (header_update),
	.use_matrix    (use_matrix),
	.matrix_level  (matrix_level)
);
